/* rtl/slwm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package slwm_pkg;

  // History depth (newest sample at cell 0)
  localparam int WINDOW   = 8;
  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 4;
  localparam int IDX_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int LEN_W    = $clog2(WINDOW + 1);

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(WINDOW);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [IDX_W-1:0]           idx_t;
  typedef logic [LEN_W-1:0]           len_t;

  // Sample travelling round the probe ring, tagged with its history position
  typedef struct packed {
    sample_t value;
    idx_t    tag;
  } probe_t;

  // Sequencer to cell row
  typedef struct packed {
    logic load;
    logic rank;
    len_t len;
  } cell_ctrl_t;

  // Zero counts as one, anything past the history saturates
  function automatic len_t eff_len(input logic [CFG_W-1:0] raw);
    len_t res;
    if (raw == '0) begin
      res = len_t'(1);
    end else if (32'(raw) > WINDOW) begin
      res = LEN_RESET;
    end else begin
      res = len_t'(raw);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/slwm_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module slwm_cell (
  input  wire                  clk,
  input  wire                  rst_n,
  input  slwm_pkg::cell_ctrl_t ctrl,
  input  slwm_pkg::idx_t       cell_idx,
  input  slwm_pkg::sample_t    hist_in,
  input  slwm_pkg::probe_t     probe_in,
  output slwm_pkg::sample_t    hist_out,
  output slwm_pkg::probe_t     probe_out,
  output logic                 is_median
);

  slwm_pkg::sample_t hist_r;
  slwm_pkg::probe_t  probe_r;
  slwm_pkg::idx_t    count_r;
  logic              beats_me;
  logic              in_window;

  // In-window probe outranks this cell: larger, or equal and newer (lower position)
  assign beats_me = (slwm_pkg::len_t'(probe_r.tag) < ctrl.len) &&
                    (($signed(probe_r.value) > $signed(hist_r)) ||
                     ((probe_r.value == hist_r) && (probe_r.tag < cell_idx)));

  assign in_window = slwm_pkg::len_t'(cell_idx) < ctrl.len;
  assign is_median = in_window &&
                     (slwm_pkg::len_t'(count_r) == (ctrl.len >> 1));

  assign hist_out  = hist_r;
  assign probe_out = probe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else if (ctrl.load) begin
      hist_r <= hist_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      probe_r.value <= hist_in;
      probe_r.tag   <= cell_idx;
      count_r       <= '0;
    end else if (ctrl.rank) begin
      probe_r <= probe_in;
      if (beats_me) begin
        count_r <= count_r + slwm_pkg::idx_t'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/sliding_window_median_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake            Payload
// in       in   in_valid / in_stall  in_sample (s16)
// out      out  out_valid / out_stall out_median (s16)
// cfg      in   cfg_valid / cfg_ready cfg_window_length (u4)
//
// A request first shifts its sample into the cell row, then the probe ring
// rotates once past every cell, and last the median is picked into the
// output register. in_stall is low only when idle; a waiting result does
// not block the next request, only the final pick.
// cfg_ready is high only when idle with no request offered, so a length
// write never lands in the middle of a ranking pass.
// Reset (synchronous, rst_n low) zeros the history and sets length to WINDOW.

module sliding_window_median_unit (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire  [15:0]              in_sample,
  output logic                     out_valid,
  input  wire                      out_stall,
  output logic [15:0]              out_median,
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire  [3:0]               cfg_window_length
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RANK,
    ST_PICK
  } state_t;

  localparam slwm_pkg::idx_t RANK_LAST = slwm_pkg::idx_t'(slwm_pkg::WINDOW - 1);

  state_t                state_r;
  slwm_pkg::idx_t        rank_cnt_r;
  slwm_pkg::len_t        len_r;
  logic                  out_valid_r;
  slwm_pkg::sample_t     out_median_r;

  slwm_pkg::cell_ctrl_t  ctrl;
  slwm_pkg::sample_t     hist [slwm_pkg::WINDOW];
  slwm_pkg::probe_t      probe [slwm_pkg::WINDOW];
  logic [slwm_pkg::WINDOW-1:0] sel_vec;
  slwm_pkg::sample_t     median_sel;
  logic                  in_take;
  logic                  out_free;

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall   = (state_r != ST_IDLE);
  assign cfg_ready  = (state_r == ST_IDLE) && !in_valid;
  assign out_valid  = out_valid_r;
  assign out_median = out_median_r;

  assign ctrl.load = in_take;
  assign ctrl.rank = (state_r == ST_RANK);
  assign ctrl.len  = len_r;

  // Cell row: history shifts towards the old end, probes circulate as a ring
  for (genvar i = 0; i < slwm_pkg::WINDOW; i++) begin : g_cell
    slwm_pkg::sample_t hist_feed;
    slwm_pkg::probe_t  probe_feed;

    if (i == 0) begin : g_head
      assign hist_feed  = slwm_pkg::sample_t'(in_sample);
      assign probe_feed = probe[slwm_pkg::WINDOW-1];
    end else begin : g_body
      assign hist_feed  = hist[i-1];
      assign probe_feed = probe[i-1];
    end

    slwm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .cell_idx  (slwm_pkg::idx_t'(i)),
      .hist_in   (hist_feed),
      .probe_in  (probe_feed),
      .hist_out  (hist[i]),
      .probe_out (probe[i]),
      .is_median (sel_vec[i])
    );
  end

  // Exactly one in-window cell has rank len/2 once the ring has gone round
  always_comb begin
    median_sel = '0;
    for (int k = 0; k < slwm_pkg::WINDOW; k++) begin
      if (sel_vec[k]) begin
        median_sel = median_sel | hist[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rank_cnt_r  <= '0;
      len_r       <= slwm_pkg::LEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        len_r <= slwm_pkg::eff_len(cfg_window_length);
      end
      unique case (state_r)
        ST_IDLE: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
          end
          if (in_take) begin
            rank_cnt_r <= '0;
            state_r    <= ST_RANK;
          end
        end
        ST_RANK: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
          end
          rank_cnt_r <= rank_cnt_r + slwm_pkg::idx_t'(1);
          if (rank_cnt_r == RANK_LAST) begin
            state_r <= ST_PICK;
          end
        end
        ST_PICK: begin
          // hold the pick until the previous result is gone
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_median_r <= median_sel;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pick_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PICK) |-> $onehot(sel_vec))
    else $error("median select not one-hot");

  a_take_starts_rank: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r == ST_RANK) && (rank_cnt_r == '0))
    else $error("accepted request did not start ranking");

  a_rank_to_pick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RANK) && (rank_cnt_r == RANK_LAST) |=> (state_r == ST_PICK))
    else $error("ranking pass did not end in pick");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r != '0) && (32'(len_r) <= slwm_pkg::WINDOW))
    else $error("window length out of range");

  a_result_on_pick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PICK) && out_free |=> out_valid_r && (state_r == ST_IDLE))
    else $error("pick did not present a result");
`endif

endmodule

`default_nettype wire
